>>> design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: ring depth,
// pointer widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

   // ring store geometry
   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   // field widths
   localparam int OP_W    = 3;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int HELD_W  = 7;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4,
      OP_COUNT      = 3'd5
   } op_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // read port address source
   typedef enum logic [1:0] {
      RD_NONE,
      RD_FRONT,
      RD_BACK,
      RD_WALK
   } rd_sel_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_DUMP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      rd_sel_type rd_sel;
      logic       emit;
      status_type emit_status;
      logic       emit_entry;
      logic       emit_final;
   } dq_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   walk_done;
   } dq_stat_type;

endpackage

>>> design/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, front pointer, occupancy count, dump walk counter and the
// registered result outputs. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module dq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dq_pkg::OP_W-1:0]          req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   input  dq_pkg::dq_cmd_type               cmd,
   output dq_pkg::dq_stat_type              stat,
   output logic                             rsp_valid,
   output logic [dq_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_entry,
   output logic [dq_pkg::HELD_W-1:0]        rsp_held,
   output logic                             rsp_final_res
);
   import dq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   op_type            op_ff;
   logic [DATA_W-1:0] value_ff;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic [PTR_W-1:0]  wr_addr;
   logic              wr_en;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_entry_ff;
   logic [HELD_W-1:0] rsp_held_ff;
   logic              rsp_final_ff;

   // position of the entry at an offset from the front, wrapped on the ring
   function automatic logic [PTR_W-1:0] ring_at(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // status back to the controller
   assign stat.op        = op_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_FULL);
   assign stat.walk_done = (walk_ff == count_ff);

   // pointer and count updates
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = ring_at(front_ff, count_ff);
      if (cmd.push_front) begin
         front_in = (front_ff == '0) ? PTR_LAST : front_ff - PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
         wr_en    = 1'b1;
         wr_addr  = front_in;
      end else if (cmd.push_back) begin
         count_in = count_ff + CNT_W'(1);
         wr_en    = 1'b1;
      end else if (cmd.pop_front) begin
         front_in = (front_ff == PTR_LAST) ? '0 : front_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
      // last entry gone: front goes home
      if ((cmd.pop_front || cmd.pop_back) && count_in == '0) begin
         front_in = '0;
      end
   end

   // read address select
   always_comb begin
      walk_in = walk_ff;
      rd_addr = front_ff;
      case (cmd.rd_sel)
         RD_FRONT: rd_addr = front_ff;
         RD_BACK:  rd_addr = ring_at(front_ff, count_ff - CNT_W'(1));
         RD_WALK: begin
            rd_addr = ring_at(front_ff, walk_ff);
            walk_in = walk_ff + CNT_W'(1);
         end
         default:  rd_addr = front_ff;
      endcase
      if (cmd.load) begin
         walk_in = '0;
      end
   end

   // ring store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.rd_sel != RD_NONE) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // captured item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
      end
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_entry_ff  <= cmd.emit_entry ? rd_data_ff : '0;
         rsp_held_ff   <= HELD_W'(count_in);
         rsp_final_ff  <= cmd.emit_final;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_held      = rsp_held_ff;
   assign rsp_final_res = rsp_final_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("occupancy beyond depth");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> front_ff == '0)
      else $error("stale front pointer on empty queue");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= count_ff)
      else $error("dump walk past the back");

   a_full_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_entry_ff == '0)
      else $error("entry on a failed operation");

endmodule

>>> design/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the double-ended queue: takes an item, decodes the
// operation and steps the datapath through push, pop or dump.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd,
   output logic                busy
);
   import dq_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = RD_NONE;
      cmd.emit_status = ST_OK;
      busy            = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  cmd.emit       = 1'b1;
                  cmd.emit_final = 1'b1;
                  if (stat.full) begin
                     cmd.emit_status = ST_FULL;
                  end else begin
                     cmd.push_front = (stat.op == OP_PUSH_FRONT);
                     cmd.push_back  = (stat.op == OP_PUSH_BACK);
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                     cmd.emit_final  = 1'b1;
                  end else begin
                     cmd.rd_sel = (stat.op == OP_POP_FRONT) ? RD_FRONT : RD_BACK;
                     state_in   = S_POP;
                  end
               end
               OP_DUMP: begin
                  if (stat.empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                     cmd.emit_final  = 1'b1;
                  end else begin
                     cmd.rd_sel = RD_WALK;
                     state_in   = S_DUMP;
                  end
               end
               default: begin
                  // count and unused codes
                  cmd.emit       = 1'b1;
                  cmd.emit_final = 1'b1;
               end
            endcase
         end
         S_POP: begin
            cmd.pop_front  = (stat.op == OP_POP_FRONT);
            cmd.pop_back   = (stat.op != OP_POP_FRONT);
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            cmd.emit_final = 1'b1;
            state_in       = S_IDLE;
         end
         S_DUMP: begin
            // emit the entry read last cycle, fetch the next one
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            cmd.emit_final = stat.walk_done;
            if (stat.walk_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_sel = RD_WALK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of 32-bit signed entries in a ring store.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each result shows on
// the rsp_ ports for one cycle with rsp_valid high and cannot be held off.
// Push, count, unused codes and a pop or dump of an empty queue give their
// result from the execute state, then free the block. A pop reads its entry
// in the execute state and gives it from the pop state; a dump of N entries
// fetches the first, then gives one result a cycle, the last marked by
// rsp_final_res: both read through the single registered read port of the
// ring store. The next item may be taken in the cycle the last result shows.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dq_pkg::OP_W-1:0]          req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   output logic [dq_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_entry,
   output logic [dq_pkg::HELD_W-1:0]        rsp_held,
   output logic                             rsp_final_res
);
   import dq_pkg::*;

   dq_cmd_type  cmd;
   dq_stat_type stat;

   // sequencer
   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // ring store and result register
   dq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_entry     (rsp_entry),
      .rsp_held      (rsp_held),
      .rsp_final_res (rsp_final_res)
   );

endmodule
